// File: rtl/fscr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp: shared types and constants
// Field widths, the queue item type and the fixed ramp stop table.
// ----------------------------------------------------------------------------
package fscr_pkg;

   // Width of the maximum depth register.
   localparam int LEVEL_W    = 15;
   // Width of three times a clamped depth.
   localparam int SCALED_W   = LEVEL_W + 2;
   // Quotient of (3 * depth * 65536) / level: two segment bits and 16 fraction bits.
   localparam int FRAC_W     = 16;
   localparam int QUO_W      = FRAC_W + 2;
   // Colour channels are unsigned Q1.15.
   localparam int COLOUR_W   = 16;
   localparam int RAMP_STOPS = 4;
   localparam int CHANNELS   = 3;
   // Signed product of a stop delta and an unsigned Q1.16 fraction.
   localparam int PROD_W     = (COLOUR_W + 1) + (FRAC_W + 2);
   // Decoupling queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // Channel positions within a stop.
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   typedef logic [COLOUR_W-1:0] colour_type;

   // One classified request on its way from front to back.
   typedef struct packed {
      logic                max_zero;
      logic [SCALED_W-1:0] scaled;
   } ramp_item_type;

   // Stops in Q1.15: azure, teal, gold, coral.
   localparam colour_type RAMP_STOP [RAMP_STOPS][CHANNELS] = '{
      '{16'd5243,  16'd17039, 16'd31457},
      '{16'd7209,  16'd26214, 16'd24904},
      '{16'd32113, 16'd26214, 16'd10486},
      '{16'd32768, 16'd14418, 16'd9830}
   };

endpackage
`default_nettype wire

// File: rtl/fscr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp: channel interfaces
// Valid/ready channels for depth requests, colour responses and the
// maximum depth register write.
// ----------------------------------------------------------------------------

// Depth request channel.
interface fscr_req_if #(parameter int DEPTH_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DEPTH_BITS-1:0] depth_in;

   modport source (output valid, output depth_in, input ready);
   modport sink   (input valid, input depth_in, output ready);
endinterface

// Colour response channel.
interface fscr_rsp_if;
   import fscr_pkg::*;
   logic       valid;
   logic       ready;
   colour_type red;
   colour_type green;
   colour_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Maximum depth register write channel.
interface fscr_csr_if;
   import fscr_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] deepest_level;

   modport source (output valid, output deepest_level, input ready);
   modport sink   (input valid, input deepest_level, output ready);
endinterface
`default_nettype wire

// File: rtl/fscr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp: front end
// Holds the maximum depth register, accepts depth requests, clamps them and
// forms three times the depth for the divider.
// ----------------------------------------------------------------------------
module fscr_front #(
   parameter int DEPTH_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   fscr_req_if.sink                        req_if,
   fscr_csr_if.sink                        csr_if,
   output logic [fscr_pkg::LEVEL_W-1:0]    level,
   output logic                            item_valid,
   input  logic                            item_ready,
   output fscr_pkg::ramp_item_type         item
);
   import fscr_pkg::*;

   localparam int CMP_W = (DEPTH_BITS > LEVEL_W) ? DEPTH_BITS : LEVEL_W;

   logic [LEVEL_W-1:0]  level_ff;
   logic                valid_ff;
   logic                valid_in;
   ramp_item_type       item_ff;
   ramp_item_type       item_in;
   logic                accept;
   logic                negative;
   logic [CMP_W-1:0]    raw_ext;
   logic [CMP_W-1:0]    level_ext;
   logic [LEVEL_W-1:0]  clamped;
   logic [SCALED_W-1:0] clamped_ext;

   // The register takes a write in any cycle outside reset.
   assign csr_if.ready = !reset;
   assign level        = level_ff;

   // The output register frees up whenever the queue takes its request.
   assign req_if.ready = !reset && (!valid_ff || item_ready);
   assign accept       = req_if.valid && req_if.ready;

   // Clamp the depth into 0..level and scale it by three.
   always_comb begin
      negative  = req_if.depth_in[DEPTH_BITS-1];
      raw_ext   = CMP_W'($unsigned(req_if.depth_in));
      level_ext = CMP_W'(level_ff);
      if (negative) begin
         clamped = '0;
      end else if (raw_ext > level_ext) begin
         clamped = level_ff;
      end else begin
         clamped = raw_ext[LEVEL_W-1:0];
      end
      clamped_ext      = SCALED_W'(clamped);
      item_in.scaled   = (clamped_ext << 1) + clamped_ext;
      item_in.max_zero = (level_ff == '0);
      valid_in         = accept || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_if.valid) begin
            level_ff <= csr_if.deepest_level;
         end
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

// File: rtl/fscr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp: request queue
// A short first-in first-out queue that lets the front end and the back end
// stall independently of each other.
// ----------------------------------------------------------------------------
module fscr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  fscr_pkg::ramp_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output fscr_pkg::ramp_item_type pop_item
);
   import fscr_pkg::*;

   ramp_item_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = entries_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

// File: rtl/fscr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp: back end
// A pipelined restoring divider forms segment and fraction, one quotient bit
// per stage; then each channel is interpolated between its two stops.
// ----------------------------------------------------------------------------
module fscr_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fscr_pkg::LEVEL_W-1:0]  level,
   input  logic                          item_valid,
   output logic                          item_ready,
   input  fscr_pkg::ramp_item_type       item,
   fscr_rsp_if.source                    rsp_if
);
   import fscr_pkg::*;

   // Divider stage registers, one set per quotient bit.
   logic               div_vld_ff  [QUO_W];
   logic               div_zero_ff [QUO_W];
   logic [LEVEL_W-1:0] div_rem_ff  [QUO_W];
   logic [QUO_W-1:0]   div_dvd_ff  [QUO_W];
   logic [QUO_W-1:0]   div_quo_ff  [QUO_W];
   logic               div_vld_in  [QUO_W];
   logic               div_zero_in [QUO_W];
   logic [LEVEL_W-1:0] div_rem_in  [QUO_W];
   logic [QUO_W-1:0]   div_dvd_in  [QUO_W];
   logic [QUO_W-1:0]   div_quo_in  [QUO_W];

   // Multiply stage registers.
   logic                     mul_vld_ff;
   colour_type               mul_lo_ff   [CHANNELS];
   logic signed [PROD_W-1:0] mul_prod_ff [CHANNELS];
   colour_type               mul_lo_in   [CHANNELS];
   logic signed [PROD_W-1:0] mul_prod_in [CHANNELS];

   // Output register.
   logic       out_vld_ff;
   colour_type out_colour_ff [CHANNELS];
   colour_type out_colour_in [CHANNELS];

   logic                    advance;
   logic [1:0]              seg;
   logic [1:0]              seg_next;
   logic [FRAC_W:0]         frac;
   logic [QUO_W-1:0]        quo_last;
   logic signed [COLOUR_W:0] delta [CHANNELS];

   // The whole back end moves together whenever the output register can take
   // a new response.
   assign advance    = !out_vld_ff || rsp_if.ready;
   assign item_ready = advance;

   // One restoring division step per stage on (3 * depth) << 16.
   always_comb begin
      logic               vld_q;
      logic               zero_q;
      logic [LEVEL_W-1:0] rem_q;
      logic [QUO_W-1:0]   dvd_q;
      logic [QUO_W-1:0]   quo_q;
      logic [LEVEL_W:0]   trial;
      logic               fits;
      for (int k = 0; k < QUO_W; k++) begin
         if (k == 0) begin
            vld_q  = item_valid;
            zero_q = item.max_zero;
            rem_q  = item.scaled[SCALED_W-1:2];
            dvd_q  = {item.scaled[1:0], {FRAC_W{1'b0}}};
            quo_q  = '0;
         end else begin
            vld_q  = div_vld_ff[k-1];
            zero_q = div_zero_ff[k-1];
            rem_q  = div_rem_ff[k-1];
            dvd_q  = div_dvd_ff[k-1];
            quo_q  = div_quo_ff[k-1];
         end
         trial          = {rem_q, dvd_q[QUO_W-1]};
         fits           = (trial >= {1'b0, level});
         div_vld_in[k]  = vld_q;
         div_zero_in[k] = zero_q;
         div_rem_in[k]  = fits ? LEVEL_W'(trial - {1'b0, level}) : trial[LEVEL_W-1:0];
         div_dvd_in[k]  = dvd_q << 1;
         div_quo_in[k]  = {quo_q[QUO_W-2:0], fits};
      end
   end

   // Segment and fraction, with the ramp end and an empty range folded in.
   always_comb begin
      quo_last = div_quo_ff[QUO_W-1];
      seg      = quo_last[QUO_W-1:FRAC_W];
      frac     = {1'b0, quo_last[FRAC_W-1:0]};
      if (div_zero_ff[QUO_W-1]) begin
         seg  = 2'd0;
         frac = '0;
      end else if (seg == 2'd3) begin
         seg  = 2'd2;
         frac = {1'b1, {FRAC_W{1'b0}}};
      end
      seg_next = seg + 2'd1;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         mul_lo_in[ch]   = RAMP_STOP[seg][ch];
         delta[ch]       = $signed({1'b0, RAMP_STOP[seg_next][ch]})
                           - $signed({1'b0, RAMP_STOP[seg][ch]});
         mul_prod_in[ch] = PROD_W'(delta[ch]) * PROD_W'($signed({1'b0, frac}));
      end
   end

   // Add the floored scaled delta to the lower stop.
   always_comb begin
      logic signed [COLOUR_W+1:0] sum;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         sum = $signed({2'b00, mul_lo_ff[ch]})
               + (COLOUR_W+2)'(mul_prod_ff[ch][FRAC_W+COLOUR_W:FRAC_W]);
         out_colour_in[ch] = sum[COLOUR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         for (int k = 0; k < QUO_W; k++) begin
            div_vld_ff[k] <= div_vld_in[k];
         end
         mul_vld_ff <= div_vld_ff[QUO_W-1];
         out_vld_ff <= mul_vld_ff;
      end
      if (advance) begin
         for (int k = 0; k < QUO_W; k++) begin
            div_zero_ff[k] <= div_zero_in[k];
            div_rem_ff[k]  <= div_rem_in[k];
            div_dvd_ff[k]  <= div_dvd_in[k];
            div_quo_ff[k]  <= div_quo_in[k];
         end
         for (int ch = 0; ch < CHANNELS; ch++) begin
            mul_lo_ff[ch]     <= mul_lo_in[ch];
            mul_prod_ff[ch]   <= mul_prod_in[ch];
            out_colour_ff[ch] <= out_colour_in[ch];
         end
      end
   end

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.red   = out_colour_ff[CH_RED];
   assign rsp_if.green = out_colour_ff[CH_GREEN];
   assign rsp_if.blue  = out_colour_ff[CH_BLUE];

endmodule
`default_nettype wire

// File: rtl/four_stop_color_ramp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Four-stop colour ramp
// Maps a call depth to an RGB colour on a fixed azure-teal-gold-coral ramp.
//
// Channels: req_if takes one signed depth per request; rsp_if returns one
// red/green/blue colour in Q1.15 per request, in order; csr_if writes the
// maximum depth, and is ready in every cycle outside reset.
// The path of a request, given no stall: the front register (loaded at the
// accepting edge), one queue slot, 18 divider stages (one quotient bit each),
// a multiply stage and the output register, whose edge makes the response valid.
// Throughput: one request per cycle while the receiver does not stall, set
// by the fully pipelined divider.
// Reset clears the maximum depth to zero and empties every stage and the
// queue; the block takes requests in the cycle after reset falls.
// When the receiver stalls, the back end holds in place and the four-entry
// queue and front register keep filling; req_if.ready falls only once they
// are full. The maximum depth must only change while the block is empty.
// ----------------------------------------------------------------------------
module four_stop_color_ramp #(
   parameter int DEPTH_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   fscr_req_if.sink    req_if,
   fscr_rsp_if.source  rsp_if,
   fscr_csr_if.sink    csr_if
);
   import fscr_pkg::*;

   logic [LEVEL_W-1:0] level;
   logic               front_valid;
   logic               front_ready;
   ramp_item_type      front_item;
   logic               queue_valid;
   logic               queue_ready;
   ramp_item_type      queue_item;

   // Accept, clamp and scale requests.
   fscr_front #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .csr_if     (csr_if),
      .level      (level),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // Decouple front and back.
   fscr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   // Divide and interpolate.
   fscr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .level      (level),
      .item_valid (queue_valid),
      .item_ready (queue_ready),
      .item       (queue_item),
      .rsp_if     (rsp_if)
   );

endmodule
`default_nettype wire
